// ===== rtl/core/ttahr_pkg.sv =====
// Shared types and constants for the threshold-triggered attack-hold-release envelope.
package ttahr_pkg;

  // Fixed field widths.
  localparam int LEVEL_W     = 16;
  localparam int COEFF_W     = 16;
  localparam int THRESH_W    = 16;
  localparam int HOLD_CFG_W  = 24;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 4;
  localparam int PHASE_W     = 2;

  // Envelope phases.
  localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_ATTACK  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_HOLD    = 2'd2;
  localparam logic [PHASE_W-1:0] PH_RELEASE = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK    = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD      = 4'd3;

  // Level constants, Q1.15 unsigned.
  localparam logic [LEVEL_W-1:0] FULL_LEVEL    = 16'd32768;
  localparam logic [LEVEL_W-1:0] ATTACK_DONE   = 16'd32735;
  localparam logic [LEVEL_W-1:0] RELEASE_FLOOR = 16'd33;

  // Register reset values.
  localparam logic [THRESH_W-1:0]   THRESHOLD_RESET = 16'd32768;
  localparam logic [COEFF_W-1:0]    COEFF_RESET     = 16'd65535;
  localparam logic [HOLD_CFG_W-1:0] HOLD_RESET      = 24'd0;

  typedef struct packed {
    logic [THRESH_W-1:0]   threshold_level;
    logic [COEFF_W-1:0]    attack_coeff;
    logic [COEFF_W-1:0]    release_coeff;
    logic [HOLD_CFG_W-1:0] hold_length;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [LEVEL_W-1:0] level;
    logic               active;
  } env_state_t;

endpackage

// ===== rtl/core/ttahr_cfg_regs.sv =====
// Configuration register bank of the envelope block.
module ttahr_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ttahr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ttahr_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ttahr_pkg::cfg_t                     cfg
);

  ttahr_pkg::cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (cfg_we) begin
      unique case (cfg_index)
        ttahr_pkg::REG_THRESHOLD:
          cfg_next.threshold_level = cfg_data[ttahr_pkg::THRESH_W-1:0];
        ttahr_pkg::REG_ATTACK:
          cfg_next.attack_coeff = cfg_data[ttahr_pkg::COEFF_W-1:0];
        ttahr_pkg::REG_RELEASE:
          cfg_next.release_coeff = cfg_data[ttahr_pkg::COEFF_W-1:0];
        ttahr_pkg::REG_HOLD:
          cfg_next.hold_length = cfg_data[ttahr_pkg::HOLD_CFG_W-1:0];
        default: begin
          // Writes to unused indexes are dropped.
          cfg_next = cfg;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_level <= ttahr_pkg::THRESHOLD_RESET;
      cfg.attack_coeff    <= ttahr_pkg::COEFF_RESET;
      cfg.release_coeff   <= ttahr_pkg::COEFF_RESET;
      cfg.hold_length     <= ttahr_pkg::HOLD_RESET;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// ===== rtl/core/ttahr_trigger.sv =====
// Sample magnitude and threshold compare that produce the trigger flag.
module ttahr_trigger #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic signed [SAMPLE_WIDTH-1:0]   sample,
  input  logic [ttahr_pkg::THRESH_W-1:0]   threshold_level,
  output logic                             trig
);

  localparam int CMP_W = (SAMPLE_WIDTH > ttahr_pkg::THRESH_W) ? SAMPLE_WIDTH
                                                              : ttahr_pkg::THRESH_W;

  logic [SAMPLE_WIDTH-1:0] sample_u;
  logic [SAMPLE_WIDTH-1:0] sample_neg;
  logic [SAMPLE_WIDTH-1:0] magnitude;
  logic [CMP_W-1:0]        mag_ext;
  logic [CMP_W-1:0]        thr_ext;

  // The full-scale negative value keeps its magnitude as an unsigned number.
  assign sample_u   = sample;
  assign sample_neg = ~sample_u + {{(SAMPLE_WIDTH-1){1'b0}}, 1'b1};
  assign magnitude  = sample_u[SAMPLE_WIDTH-1] ? sample_neg : sample_u;
  assign mag_ext    = CMP_W'(magnitude);
  assign thr_ext    = CMP_W'(threshold_level);
  assign trig       = (mag_ext > thr_ext);

endmodule

// ===== rtl/core/ttahr_step.sv =====
// Next-state logic of the envelope: trigger handling, phase update and level arithmetic.
module ttahr_step #(
  parameter int HOLD_WIDTH = 24
) (
  input  ttahr_pkg::cfg_t         cfg,
  input  ttahr_pkg::env_state_t   st,
  input  logic [HOLD_WIDTH-1:0]   hold_count,
  input  logic                    trig,
  output ttahr_pkg::env_state_t   st_next,
  output logic [HOLD_WIDTH-1:0]   hold_count_next
);

  localparam int HOLD_EXT_W = (HOLD_WIDTH > ttahr_pkg::HOLD_CFG_W) ? HOLD_WIDTH
                                                                   : ttahr_pkg::HOLD_CFG_W;

  logic [HOLD_EXT_W-1:0]             hold_ext;
  logic [HOLD_WIDTH-1:0]             hold_reload;
  logic [ttahr_pkg::PHASE_W-1:0]     phase_trig;
  logic [HOLD_WIDTH-1:0]             hold_trig;
  logic [HOLD_WIDTH-1:0]             hold_dec;
  logic                              active_trig;
  logic [ttahr_pkg::LEVEL_W-1:0]     gap;
  logic [ttahr_pkg::COEFF_W-1:0]     mul_a;
  logic [ttahr_pkg::LEVEL_W-1:0]     mul_b;
  logic [ttahr_pkg::COEFF_W+ttahr_pkg::LEVEL_W-1:0] product;
  logic [ttahr_pkg::LEVEL_W-1:0]     prod_hi;
  logic [ttahr_pkg::LEVEL_W:0]       attack_sum;
  logic [ttahr_pkg::LEVEL_W-1:0]     release_diff;

  assign hold_ext    = HOLD_EXT_W'(cfg.hold_length);
  assign hold_reload = hold_ext[HOLD_WIDTH-1:0];

  // A trigger reloads the hold counter and restarts attack from idle or release.
  always_comb begin
    phase_trig  = st.phase;
    hold_trig   = hold_count;
    active_trig = st.active;
    if (trig) begin
      active_trig = 1'b1;
      hold_trig   = hold_reload;
      if ((st.phase == ttahr_pkg::PH_IDLE) || (st.phase == ttahr_pkg::PH_RELEASE)) begin
        phase_trig = ttahr_pkg::PH_ATTACK;
      end
    end
  end

  // One multiplier serves both attack and release.
  assign gap     = (st.level < ttahr_pkg::FULL_LEVEL) ? (ttahr_pkg::FULL_LEVEL - st.level)
                                                      : '0;
  assign mul_a   = (phase_trig == ttahr_pkg::PH_ATTACK) ? cfg.attack_coeff : cfg.release_coeff;
  assign mul_b   = (phase_trig == ttahr_pkg::PH_ATTACK) ? gap : st.level;
  assign product = mul_a * mul_b;
  assign prod_hi = product[ttahr_pkg::COEFF_W+ttahr_pkg::LEVEL_W-1:ttahr_pkg::COEFF_W];

  assign attack_sum   = {1'b0, st.level} + {1'b0, prod_hi};
  assign release_diff = (prod_hi <= st.level) ? (st.level - prod_hi) : '0;
  assign hold_dec     = (hold_trig != '0) ? (hold_trig - {{(HOLD_WIDTH-1){1'b0}}, 1'b1})
                                          : hold_trig;

  always_comb begin
    st_next.phase   = phase_trig;
    st_next.level   = st.level;
    st_next.active  = active_trig;
    hold_count_next = hold_trig;
    unique case (phase_trig)
      ttahr_pkg::PH_IDLE: begin
        st_next.level = '0;
      end
      ttahr_pkg::PH_ATTACK: begin
        if (attack_sum >= {1'b0, ttahr_pkg::ATTACK_DONE}) begin
          st_next.level = ttahr_pkg::FULL_LEVEL;
          st_next.phase = ttahr_pkg::PH_HOLD;
        end else begin
          st_next.level = attack_sum[ttahr_pkg::LEVEL_W-1:0];
        end
      end
      ttahr_pkg::PH_HOLD: begin
        st_next.level   = ttahr_pkg::FULL_LEVEL;
        hold_count_next = hold_dec;
        if ((hold_dec == '0) && !trig) begin
          st_next.phase = ttahr_pkg::PH_RELEASE;
        end
      end
      default: begin
        if (release_diff < ttahr_pkg::RELEASE_FLOOR) begin
          st_next.level  = '0;
          st_next.phase  = ttahr_pkg::PH_IDLE;
          st_next.active = 1'b0;
        end else begin
          st_next.level = release_diff;
        end
      end
    endcase
  end

endmodule

// ===== rtl/core/threshold_triggered_ahr_envelope.sv =====
// Top level of the threshold-triggered attack-hold-release envelope generator.
// An accepted transaction passes the input stage and then the result register.
// Throughput: one sample per cycle while out_ready is high; the envelope state loop
// closes through one 16 x 16 multiplier, so the next sample uses it at once.
// Reset (synchronous, active high) empties both stages, sets the envelope to idle
// with zero level and hold count, and loads the register reset values.
module threshold_triggered_ahr_envelope #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int HOLD_WIDTH   = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Sample channel.
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample,
  // Result channel.
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ttahr_pkg::LEVEL_W-1:0]          envelope,
  output logic [ttahr_pkg::PHASE_W-1:0]          phase,
  output logic                                   active,
  // Configuration write port.
  input  logic                                   cfg_we,
  input  logic [ttahr_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [ttahr_pkg::CFG_DATA_W-1:0]       cfg_data
);

  ttahr_pkg::cfg_t       cfg;
  ttahr_pkg::env_state_t st;
  ttahr_pkg::env_state_t st_next;
  logic [HOLD_WIDTH-1:0] hold_count;
  logic [HOLD_WIDTH-1:0] hold_count_next;

  // Input stage: holds only the trigger decision of the accepted sample. The user must
  // not change the threshold while a transaction is in flight (the block does not enforce
  // it), so comparing at acceptance gives the same answer as comparing at the update.
  logic s1_valid;
  logic s1_trig;
  logic in_trig;

  // The input stage moves into the result register whenever that register is
  // empty or its transaction is being taken in this cycle.
  logic advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  ttahr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ttahr_trigger #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_trigger (
    .sample          (sample),
    .threshold_level (cfg.threshold_level),
    .trig            (in_trig)
  );

  ttahr_step #(
    .HOLD_WIDTH (HOLD_WIDTH)
  ) u_step (
    .cfg             (cfg),
    .st              (st),
    .hold_count      (hold_count),
    .trig            (s1_trig),
    .st_next         (st_next),
    .hold_count_next (hold_count_next)
  );

  // Input stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_trig <= in_trig;
    end
  end

  // Envelope state. It moves on exactly once per transaction, at the moment the
  // transaction enters the result register, so every result sees the state left
  // by the one before it.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase   <= ttahr_pkg::PH_IDLE;
      st.level   <= '0;
      st.active  <= 1'b0;
      hold_count <= '0;
    end else if (advance) begin
      st         <= st_next;
      hold_count <= hold_count_next;
    end
  end

  // Result register. It keeps its transaction until the consumer takes it,
  // while a new sample may already wait in the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      envelope <= st_next.level;
      phase    <= st_next.phase;
      active   <= st_next.active;
    end
  end

`ifndef SYNTHESIS
  // The envelope is never above full level.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (envelope <= ttahr_pkg::FULL_LEVEL))
    else $error("envelope above full level");

  // An idle result carries zero level and a cleared active flag.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (phase == ttahr_pkg::PH_IDLE)) |-> ((envelope == '0) && !active))
    else $error("idle result with non-zero level or active set");

  // Hold always reports full level.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (phase == ttahr_pkg::PH_HOLD)) |-> (envelope == ttahr_pkg::FULL_LEVEL))
    else $error("hold result below full level");

  // The active flag is clear exactly when the envelope state is idle.
  assert property (@(posedge clk) disable iff (rst)
    (st.phase == ttahr_pkg::PH_IDLE) == !st.active)
    else $error("active flag disagrees with idle phase");

  // The state only changes when a transaction enters the result register.
  assert property (@(posedge clk) disable iff (rst)
    !$past(advance) && !$past(rst) |-> $stable(st))
    else $error("envelope state changed without a transaction");
`endif

endmodule

// ===== tb/threshold_triggered_ahr_envelope_tb.sv =====
// Self-checking testbench for the threshold-triggered attack-hold-release envelope.
`timescale 1ns / 100ps

module testbench;
  import ttahr_pkg::*;

  // Run shape. The settle cycles cover anything still in flight.
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 4;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 141;
  localparam int LONG_HOLD_OFF   = 300;

  typedef struct packed {
    logic [LEVEL_W-1:0] lvl;
    logic [PHASE_W-1:0] ph;
    logic               act;
  } env_result_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_TYPED, ROW_WRITE} row_kind_t;

  // One row of the directed table: either a register write or a sample, the latter
  // optionally carrying a result typed in by hand.
  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_INDEX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0]   data;
    logic signed [15:0]      smp;
    env_result_t             typed;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [15:0]          sample = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [LEVEL_W-1:0]          envelope;
  logic [PHASE_W-1:0]          phase;
  logic                        active;
  logic                        cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  // Tracked copy of the envelope state and its registers, advanced once per accepted
  // sample transaction.
  cfg_t                        track_cfg;
  logic [PHASE_W-1:0]          track_phase;
  logic [LEVEL_W-1:0]          track_level;
  logic [HOLD_CFG_W-1:0]       track_hold;
  logic                        track_active;

  env_result_t                 expected_envelopes[$];
  stim_row_t                   directed_rows[$];

  int  mismatches = 0;
  int  samples_sent = 0;
  int  results_checked = 0;
  int  triggers_seen = 0;
  int  reg_writes = 0;
  int  results_in_phase[4] = '{0, 0, 0, 0};

  // Shared between the stimulus and the receiver: pacing modes for the current phase,
  // and a one-shot request for a long hold-off on the result channel.
  bit  sender_steady = 1'b0;
  bit  receiver_steady = 1'b0;
  bit  hold_off_req = 1'b0;

  // State of the loud/quiet run generator that shapes random samples.
  int  run_left = 0;
  bit  run_loud = 1'b0;

  threshold_triggered_ahr_envelope uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .envelope  (envelope),
    .phase     (phase),
    .active    (active),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Works out the result of one sample and moves the tracked state on. A trigger is
  // dealt with first (active set, hold reloaded, idle or release sent to attack), then
  // the current phase acts on the level.
  function automatic env_result_t next_envelope(input logic signed [15:0] smp);
    longint magnitude;
    longint lvl;
    longint delta;
    logic   trig;
    // The full-scale negative sample keeps its magnitude of 32768 here.
    magnitude = (smp < 0) ? -longint'(smp) : longint'(smp);
    trig = magnitude > longint'(track_cfg.threshold_level);
    lvl = longint'(track_level);
    if (trig) begin
      triggers_seen++;
      track_active = 1'b1;
      track_hold = track_cfg.hold_length;
      if (track_phase == PH_IDLE || track_phase == PH_RELEASE) begin
        track_phase = PH_ATTACK;
      end
    end
    case (track_phase)
      PH_IDLE: begin
        lvl = 0;
      end
      PH_ATTACK: begin
        delta = (longint'(track_cfg.attack_coeff) * (longint'(FULL_LEVEL) - lvl)) >> 16;
        lvl = lvl + delta;
        if (lvl >= longint'(ATTACK_DONE)) begin
          lvl = longint'(FULL_LEVEL);
          track_phase = PH_HOLD;
        end
      end
      PH_HOLD: begin
        lvl = longint'(FULL_LEVEL);
        if (track_hold != '0) begin
          track_hold = track_hold - 1'b1;
        end
        if (track_hold == '0 && !trig) begin
          track_phase = PH_RELEASE;
        end
      end
      default: begin
        delta = (longint'(track_cfg.release_coeff) * lvl) >> 16;
        lvl = lvl - delta;
        if (lvl < longint'(RELEASE_FLOOR)) begin
          lvl = 0;
          track_phase = PH_IDLE;
          track_active = 1'b0;
        end
      end
    endcase
    track_level = lvl[LEVEL_W-1:0];
    return '{track_level, track_phase, track_active};
  endfunction

  // Random samples come mostly as runs: short loud bursts above the threshold and
  // longer quiet stretches below it, so that the envelope gets all the way round its
  // cycle. A small share is raw noise or an edge value: full scale, zero or minus one.
  function automatic logic signed [15:0] pick_sample();
    int roll;
    int lim;
    int mag;
    bit neg;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      return 16'($urandom);
    end
    if (roll < 11) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh8000;
        1:       return 16'sh7fff;
        2:       return 16'sh0000;
        default: return -16'sd1;
      endcase
    end
    if (run_left == 0) begin
      run_loud = ($urandom_range(0, 2) == 0);
      run_left = run_loud ? $urandom_range(1, 4) : $urandom_range(1, 80);
    end
    run_left--;
    lim = int'(track_cfg.threshold_level);
    if (run_loud && lim < 32768) begin
      mag = $urandom_range(lim + 1, 32768);
    end else begin
      mag = $urandom_range(0, (lim > 32768) ? 32768 : lim);
    end
    neg = $urandom_range(0, 1);
    if (mag == 32768) begin
      return 16'sh8000;
    end
    return neg ? 16'(-mag) : 16'(mag);
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    return '{ROW_WRITE, idx, data, 16'sd0, env_result_t'('0)};
  endfunction

  function automatic stim_row_t sample_row(input logic signed [15:0] smp);
    return '{ROW_SAMPLE, '0, '0, smp, env_result_t'('0)};
  endfunction

  function automatic stim_row_t typed_row(input logic signed [15:0] smp,
                                          input logic [LEVEL_W-1:0] lvl,
                                          input logic [PHASE_W-1:0] ph,
                                          input logic act);
    return '{ROW_TYPED, '0, '0, smp, env_result_t'({lvl, ph, act})};
  endfunction

  // Offers one sample transaction after an optional idle gap and holds it until the
  // block takes it. The expectation is queued at the edge of acceptance.
  task automatic offer_sample(input logic signed [15:0] smp, input int gap,
                              input bit use_typed, input env_result_t typed);
    env_result_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= smp;
    do @(posedge clk); while (!in_ready);
    predicted = next_envelope(smp);
    expected_envelopes.push_back(use_typed ? typed : predicted);
    samples_sent++;
  endtask

  // Stops offering and waits until every outstanding result has been collected and the
  // settle time has passed, so that the block is quiet before its registers are touched.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_envelopes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write. Only the low bits that the register holds are kept, and an
  // index beyond the register list changes nothing.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
    case (idx)
      REG_THRESHOLD: track_cfg.threshold_level = value[THRESH_W-1:0];
      REG_ATTACK:    track_cfg.attack_coeff    = value[COEFF_W-1:0];
      REG_RELEASE:   track_cfg.release_coeff   = value[COEFF_W-1:0];
      REG_HOLD:      track_cfg.hold_length     = value[HOLD_CFG_W-1:0];
      default: ;
    endcase
  endtask

  // Result side: every accepted result transaction is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    env_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_envelopes.size() == 0) begin
        $error("result with nothing outstanding: envelope %0d phase %0d active %0d",
               envelope, phase, active);
        mismatches++;
      end else begin
        want = expected_envelopes.pop_front();
        results_checked++;
        results_in_phase[want.ph]++;
        if (envelope !== want.lvl) begin
          $error("envelope: expected %0d, got %0d", want.lvl, envelope);
          mismatches++;
        end
        if (phase !== want.ph) begin
          $error("phase: expected %0d, got %0d", want.ph, phase);
          mismatches++;
        end
        if (active !== want.act) begin
          $error("active: expected %0d, got %0d", want.act, active);
          mismatches++;
        end
      end
    end
  end

  // Receiver pacing. Normally short ready runs broken by stalls, mostly brief and now
  // and then long; a steady phase keeps ready high throughout. A hold-off request
  // drops ready for a long stretch so that the block backs up and refuses samples.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_OFF) @(posedge clk);
      end else if (receiver_steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b0;
        repeat (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40))
          @(posedge clk);
      end
    end
  end

  // Backstop: a correct run finishes far inside this.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [THRESH_W-1:0]   thr;
    logic [COEFF_W-1:0]    att;
    logic [COEFF_W-1:0]    rel;
    logic [HOLD_CFG_W-1:0] hold;
    int                    gap;

    track_cfg    = '{THRESHOLD_RESET, COEFF_RESET, COEFF_RESET, HOLD_RESET};
    track_phase  = PH_IDLE;
    track_level  = '0;
    track_hold   = '0;
    track_active = 1'b0;

    // Directed table. After reset the threshold sits at full scale, so nothing
    // triggers, not even the full-scale negative sample.
    directed_rows.push_back(typed_row(16'sh8000, 16'd0, PH_IDLE, 1'b0));
    directed_rows.push_back(typed_row(16'sh7fff, 16'd0, PH_IDLE, 1'b0));
    // Threshold written with spare high bits, which must be dropped: 0x7fff remains.
    directed_rows.push_back(write_row(REG_THRESHOLD, 24'hff7fff));
    directed_rows.push_back(typed_row(16'sh7fff, 16'd0, PH_IDLE, 1'b0));
    // Only the full-scale negative sample now exceeds the threshold. With the reset
    // coefficients attack completes in one sample, and with no hold length the first
    // quiet sample leaves hold; release then falls straight back to idle.
    directed_rows.push_back(typed_row(16'sh8000, FULL_LEVEL, PH_HOLD, 1'b1));
    directed_rows.push_back(typed_row(16'sh0000, FULL_LEVEL, PH_RELEASE, 1'b1));
    directed_rows.push_back(typed_row(16'sh0000, 16'd0, PH_IDLE, 1'b0));
    // Writes beyond the register list must leave the threshold alone.
    directed_rows.push_back(write_row(4'd5, 24'h000000));
    directed_rows.push_back(write_row(4'd15, 24'hffffff));
    directed_rows.push_back(typed_row(16'sd100, 16'd0, PH_IDLE, 1'b0));
    // Zero attack coefficient: the block enters attack and stays at zero level.
    directed_rows.push_back(write_row(REG_ATTACK, 24'h000000));
    directed_rows.push_back(write_row(REG_HOLD, 24'd2));
    directed_rows.push_back(write_row(REG_THRESHOLD, 24'd1000));
    directed_rows.push_back(typed_row(16'sd1001, 16'd0, PH_ATTACK, 1'b1));
    directed_rows.push_back(typed_row(16'sd0, 16'd0, PH_ATTACK, 1'b1));
    // A real attack, retriggered on the way up, then a trigger during hold.
    directed_rows.push_back(write_row(REG_ATTACK, 24'h00c000));
    directed_rows.push_back(sample_row(-16'sd1001));
    directed_rows.push_back(sample_row(16'sd0));
    directed_rows.push_back(sample_row(16'sd0));
    directed_rows.push_back(sample_row(16'sd0));
    directed_rows.push_back(sample_row(16'sd0));
    directed_rows.push_back(sample_row(16'sd1500));
    // Zero release coefficient: release holds its level until the next trigger.
    directed_rows.push_back(write_row(REG_RELEASE, 24'h000000));
    directed_rows.push_back(sample_row(16'sd0));
    directed_rows.push_back(sample_row(16'sd0));
    directed_rows.push_back(sample_row(16'sd0));
    // Retrigger out of release at full level, then a proper decay, then a retrigger
    // part way down.
    directed_rows.push_back(write_row(REG_RELEASE, 24'h004000));
    directed_rows.push_back(sample_row(-16'sd2000));
    directed_rows.push_back(sample_row(16'sd0));
    directed_rows.push_back(sample_row(16'sd0));
    directed_rows.push_back(sample_row(16'sd0));
    directed_rows.push_back(sample_row(16'sd0));
    directed_rows.push_back(sample_row(16'sd4000));
    directed_rows.push_back(sample_row(16'sd0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_WRITE: begin
          settle();
          write_reg(directed_rows[i].idx, directed_rows[i].data);
        end
        ROW_TYPED: begin
          offer_sample(directed_rows[i].smp, $urandom_range(0, 2), 1'b1,
                       directed_rows[i].typed);
        end
        default: begin
          offer_sample(directed_rows[i].smp, $urandom_range(0, 2), 1'b0, '0);
        end
      endcase
    end

    // Random phases, each under its own register setting. The first two take the
    // extremes; the third pins the hold length at its maximum so that hold is
    // reloaded with the largest count; the rest draw settings that let the envelope
    // complete its cycle within a phase.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      thr  = 16'($urandom_range(0, 30000));
      att  = 16'($urandom_range(6000, 65535));
      rel  = 16'($urandom_range(6000, 65535));
      hold = 24'($urandom_range(0, 12));
      case (p)
        0: begin
          thr  = '0;
          att  = 16'hffff;
          rel  = 16'hffff;
          hold = '0;
        end
        1: begin
          thr  = 16'hffff;
          att  = '0;
          rel  = '0;
          hold = 24'hffffff;
        end
        2: begin
          hold = 24'hffffff;
        end
        default: ;
      endcase
      write_reg(REG_THRESHOLD, {8'($urandom), thr});
      write_reg(REG_ATTACK, {8'($urandom), att});
      write_reg(REG_RELEASE, {8'($urandom), rel});
      write_reg(REG_HOLD, hold);
      write_reg(4'($urandom_range(4, 15)), 24'($urandom));

      // The fifth phase backs the block up behind a long receiver hold-off while samples
      // keep coming; the sixth runs with no idling on either side.
      sender_steady   = (p == 4 || p == 5);
      receiver_steady = (p == 5);
      if (p == 4) begin
        hold_off_req = 1'b1;
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (sender_steady) begin
          gap = 0;
        end else begin
          gap = $urandom_range(0, 99);
          gap = (gap < 65) ? 0 : (gap < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
        offer_sample(pick_sample(), gap, 1'b0, '0);
      end
    end

    settle();
    receiver_steady = 1'b0;
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (expected_envelopes.size() != 0) begin
      $error("%0d results never arrived", expected_envelopes.size());
      mismatches++;
    end

    $display("Run covered %0d samples (%0d triggering) and %0d checked results, %0d writes.",
             samples_sent, triggers_seen, results_checked, reg_writes);
    $display("Results by phase: idle %0d, attack %0d, hold %0d, release %0d.",
             results_in_phase[0], results_in_phase[1], results_in_phase[2],
             results_in_phase[3]);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
